// ===== design/tzx_block_scanner_duration_defines.svh =====
// Assertion helpers used by the scanner's total module.
`ifndef TZX_BLOCK_SCANNER_DURATION_DEFINES_SVH
`define TZX_BLOCK_SCANNER_DURATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TZXBSD_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TZXBSD_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tzxbsd_pkg.sv =====
package tzxbsd_pkg;

	localparam logic [31:0] HEADER_BYTES = 32'd10;

	// Reciprocal multipliers: x/3500 = ((x>>2)*M)>>40, x/1000 = ((x>>3)*M)>>36
	localparam logic [30:0] DIV875_MUL = 31'd1256584718;
	localparam logic [29:0] DIV125_MUL = 30'd549755814;
	localparam logic [31:0] STD_PILOT_TERM = 32'd6981440;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_SIG = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;
	localparam logic [1:0] ST_UNSUP = 2'd3;

	localparam logic [7:0] ID_STD = 8'h10;
	localparam logic [7:0] ID_TURBO = 8'h11;
	localparam logic [7:0] ID_TONE = 8'h12;
	localparam logic [7:0] ID_PULSES = 8'h13;
	localparam logic [7:0] ID_PURE = 8'h14;
	localparam logic [7:0] ID_DIRECT = 8'h15;
	localparam logic [7:0] ID_PAUSE = 8'h20;
	localparam logic [7:0] ID_GRP_START = 8'h21;
	localparam logic [7:0] ID_GRP_END = 8'h22;
	localparam logic [7:0] ID_JUMP = 8'h23;
	localparam logic [7:0] ID_LOOP_START = 8'h24;
	localparam logic [7:0] ID_LOOP_END = 8'h25;
	localparam logic [7:0] ID_CALL_SEQ = 8'h26;
	localparam logic [7:0] ID_RET_SEQ = 8'h27;
	localparam logic [7:0] ID_SELECT = 8'h28;
	localparam logic [7:0] ID_TEXT = 8'h30;
	localparam logic [7:0] ID_MESSAGE = 8'h31;
	localparam logic [7:0] ID_ARCHIVE = 8'h32;
	localparam logic [7:0] ID_HARDWARE = 8'h33;
	localparam logic [7:0] ID_EMU_INFO = 8'h34;
	localparam logic [7:0] ID_CUSTOM = 8'h35;
	localparam logic [7:0] ID_SNAPSHOT = 8'h40;
	localparam logic [7:0] ID_GLUE = 8'h5A;

	typedef enum logic [1:0] {PH_HEADER, PH_ID, PH_BODY, PH_BAD} phase_t;

	// First 16 body bytes, index = body position
	typedef logic [15:0][7:0] hdr_t;

	typedef struct packed {
		logic blk;
		logic [7:0] id;
		logic [31:0] offset;
		logic [32:0] length;
		logic done;
		logic [1:0] status;
	} info_t;

	// Four (a*b mod 2^32)/3500 terms plus a pause addend
	typedef struct packed {
		logic [3:0][15:0] a;
		logic [3:0][31:0] b;
		logic [15:0] addend;
	} ops_t;

	typedef struct packed {
		logic known;
		logic [3:0] len;
		logic [4:0] key;
	} rule_t;

	typedef struct packed {
		logic has;
		logic [4:0] pos;
	} dstart_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] i);
		case (i)
			3'd0: sig_byte = 8'h5A;
			3'd1: sig_byte = 8'h58;
			3'd2: sig_byte = 8'h54;
			3'd3: sig_byte = 8'h61;
			3'd4: sig_byte = 8'h70;
			3'd5: sig_byte = 8'h65;
			3'd6: sig_byte = 8'h21;
			default: sig_byte = 8'h1A;
		endcase
	endfunction

	// Length known at the ID byte, or the body position that settles it
	function automatic rule_t start_rule(input logic [7:0] id);
		rule_t r;
		r = '{known: 1'b0, len: 4'd0, key: 5'd3};
		case (id)
			ID_TONE: r = '{known: 1'b1, len: 4'd4, key: 5'd0};
			ID_PAUSE, ID_JUMP, ID_LOOP_START: r = '{known: 1'b1, len: 4'd2, key: 5'd0};
			ID_GRP_END, ID_LOOP_END, ID_RET_SEQ: r = '{known: 1'b1, len: 4'd0, key: 5'd0};
			ID_EMU_INFO: r = '{known: 1'b1, len: 4'd8, key: 5'd0};
			ID_GLUE: r = '{known: 1'b1, len: 4'd9, key: 5'd0};
			ID_TURBO: r.key = 5'd17;
			ID_PULSES, ID_GRP_START, ID_TEXT, ID_HARDWARE: r.key = 5'd0;
			ID_PURE: r.key = 5'd9;
			ID_DIRECT: r.key = 5'd7;
			ID_CALL_SEQ, ID_SELECT, ID_MESSAGE, ID_ARCHIVE: r.key = 5'd1;
			ID_CUSTOM: r.key = 5'd19;
			default: r.key = 5'd3;
		endcase
		return r;
	endfunction

	function automatic dstart_t data_start(input logic [7:0] id);
		case (id)
			ID_STD: data_start = '{has: 1'b1, pos: 5'd4};
			ID_TURBO: data_start = '{has: 1'b1, pos: 5'd18};
			ID_PURE: data_start = '{has: 1'b1, pos: 5'd10};
			default: data_start = '{has: 1'b0, pos: 5'd0};
		endcase
	endfunction

	// Body length once the length field is complete
	function automatic logic [32:0] body_len_rule(input logic [7:0] id, input hdr_t h,
			input logic [31:0] ext);
		case (id)
			ID_STD: body_len_rule = 33'({h[3], h[2]}) + 33'd4;
			ID_TURBO: body_len_rule = 33'({ext[15:0], h[15]}) + 33'd18;
			ID_PULSES: body_len_rule = 33'({h[0], 1'b1});
			ID_PURE: body_len_rule = 33'({h[9], h[8], h[7]}) + 33'd10;
			ID_DIRECT: body_len_rule = 33'({h[7], h[6], h[5]}) + 33'd8;
			ID_GRP_START, ID_TEXT: body_len_rule = 33'(h[0]) + 33'd1;
			ID_CALL_SEQ: body_len_rule = 33'({h[1], h[0], 1'b0}) + 33'd2;
			ID_SELECT, ID_ARCHIVE: body_len_rule = 33'({h[1], h[0]}) + 33'd2;
			ID_MESSAGE: body_len_rule = 33'(h[1]) + 33'd2;
			ID_HARDWARE: body_len_rule = 33'({h[0], 1'b0}) + 33'(h[0]) + 33'd1;
			ID_CUSTOM: body_len_rule = 33'(ext) + 33'd20;
			ID_SNAPSHOT: body_len_rule = 33'({h[3], h[2], h[1]}) + 33'd4;
			default: body_len_rule = 33'({h[3], h[2], h[1], h[0]}) + 33'd4;
		endcase
	endfunction

endpackage

// ===== design/tzx_block_scanner_duration.sv =====
// Tape image block scanner with play-time estimate.
// Input channel (in_valid/in_ready): one image byte per item, last_byte marking
// the final byte. Items may be sent every cycle; in_ready is low only while the
// output register holds a result the receiver has not taken.
// Output channel (out_valid/out_ready): one item per finished block and one for
// the last byte (both on one item when the last byte ends a block). Bytes that
// finish nothing produce no item.
// Throughput: one byte per cycle while the receiver takes results, set by
// the single-pass parser register and the four result stages behind it
// (term multiply, divide by 3500, sum and accumulate, seconds and clamp).
// Configuration (cfg_valid/cfg_ready, cfg_data): the saturation limit in
// seconds, always ready; write it only while no item is in flight.
// Reset clears the parser, the pipeline and the running time and sets the
// limit to 65535. After the last byte of an image the parser starts afresh.
// A stalled receiver freezes every stage; the result stays on the outputs.
module tzx_block_scanner_duration (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data,
	output logic out_valid,
	input  logic out_ready,
	output logic block_valid,
	output logic [7:0] tape_id,
	output logic [31:0] block_offset,
	output logic [32:0] block_length,
	output logic [31:0] start_ms,
	output logic [31:0] play_time_ms,
	output logic image_done,
	output logic [1:0] status,
	output logic [15:0] total_seconds
);

	logic advance, acc, vld_s1, vld_s3;
	tzxbsd_pkg::info_t info_s1, info_s3, info_s5;
	tzxbsd_pkg::ops_t ops_s1;
	logic [3:0][20:0] quot_s3;
	logic [15:0] add_s3, max_q;

	// Move the whole pipeline unless the output item is stuck
	assign advance = !out_valid || out_ready;
	assign in_ready = advance;
	assign acc = in_valid && advance;
	assign cfg_ready = 1'b1;

	// Hold the saturation limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 16'hFFFF;
		end else if (cfg_valid) begin
			max_q <= cfg_data;
		end
	end

	tzxbsd_parse u_parse (
		.clk(clk), .arst_n(arst_n), .acc(acc), .advance(advance),
		.data_byte(data_byte), .last_byte(last_byte),
		.vld_s1(vld_s1), .info_s1(info_s1), .ops_s1(ops_s1)
	);

	tzxbsd_conv u_conv (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.vld_s1(vld_s1), .info_s1(info_s1), .ops_s1(ops_s1),
		.vld_s3(vld_s3), .info_s3(info_s3), .quot_s3(quot_s3), .add_s3(add_s3)
	);

	tzxbsd_total u_total (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.vld_s3(vld_s3), .info_s3(info_s3), .quot_s3(quot_s3), .add_s3(add_s3),
		.max_q(max_q), .vld_s5(out_valid), .info_s5(info_s5),
		.toff_s5(start_ms), .dur_s5(play_time_ms), .secs_s5(total_seconds)
	);

	assign block_valid = info_s5.blk;
	assign tape_id = info_s5.id;
	assign block_offset = info_s5.offset;
	assign block_length = info_s5.length;
	assign image_done = info_s5.done;
	assign status = info_s5.status;

endmodule

// ===== design/tzxbsd_parse.sv =====
module tzxbsd_parse (
	input  logic clk,
	input  logic arst_n,
	input  logic acc,
	input  logic advance,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	output logic vld_s1,
	output tzxbsd_pkg::info_t info_s1,
	output tzxbsd_pkg::ops_t ops_s1
);

	tzxbsd_pkg::phase_t phase_q, phase_n;
	logic [31:0] bpos_q, bpos_n, bstart_q, bstart_n;
	logic [7:0] id_q, id_n;
	tzxbsd_pkg::hdr_t hdr_q, hdr_n;
	logic [31:0] ext_q, ext_n, ones_q, ones_n, pulse_q, pulse_n;
	logic [32:0] rem_q, rem_n, blen_q, blen_n;
	logic [1:0] err_q, err_n;
	logic [4:0] ppos_q, ppos_n, key_q, key_n;
	logic odd_q, odd_n, known_q, known_n, seen_q, seen_n;
	logic done;
	logic [1:0] st;
	tzxbsd_pkg::rule_t rule;
	tzxbsd_pkg::dstart_t ds;

	function automatic logic [3:0] popc(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(v[i]);
		end
		return c;
	endfunction

	// Operands of the play-time terms for a finished block
	function automatic tzxbsd_pkg::ops_t build_ops(input logic [7:0] id,
			input tzxbsd_pkg::hdr_t h, input logic [31:0] ones, input logic [31:0] pulse,
			input logic [32:0] blen);
		tzxbsd_pkg::ops_t o;
		logic [31:0] ns;
		o = '0;
		ns = 32'd0;
		case (id)
			tzxbsd_pkg::ID_STD: begin
				ns = {13'd0, h[3], h[2], 3'b000};
				o.a[0] = 16'd1;
				o.b[0] = tzxbsd_pkg::STD_PILOT_TERM;
				o.a[1] = 16'd1710;
				o.b[1] = ones << 1;
				o.a[2] = 16'd855;
				o.b[2] = (ns - ones) << 1;
				o.addend = {h[1], h[0]};
			end
			tzxbsd_pkg::ID_TURBO: begin
				ns = ((blen[31:0] - 32'd19) << 3) + 32'(h[12]);
				o.a[0] = {h[1], h[0]};
				o.b[0] = 32'({h[11], h[10]});
				o.a[1] = 16'd1;
				o.b[1] = 32'({h[3], h[2]}) + 32'({h[5], h[4]});
				o.a[2] = {h[9], h[8]};
				o.b[2] = ones << 1;
				o.a[3] = {h[7], h[6]};
				o.b[3] = (ns - ones) << 1;
				o.addend = {h[14], h[13]};
			end
			tzxbsd_pkg::ID_TONE: begin
				o.a[0] = {h[1], h[0]};
				o.b[0] = 32'({h[3], h[2]});
			end
			tzxbsd_pkg::ID_PULSES: begin
				o.a[0] = 16'd1;
				o.b[0] = pulse;
			end
			tzxbsd_pkg::ID_PURE: begin
				ns = ((blen[31:0] - 32'd11) << 3) + 32'(h[4]);
				o.a[0] = {h[3], h[2]};
				o.b[0] = ones << 1;
				o.a[1] = {h[1], h[0]};
				o.b[1] = (ns - ones) << 1;
				o.addend = {h[6], h[5]};
			end
			tzxbsd_pkg::ID_DIRECT: begin
				ns = ((blen[31:0] - 32'd9) << 3) + 32'(h[4]);
				o.a[0] = {h[1], h[0]};
				o.b[0] = ns;
				o.addend = {h[3], h[2]};
			end
			tzxbsd_pkg::ID_PAUSE: begin
				o.addend = {h[1], h[0]};
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	// Work out the parser's next state for an accepted item
	always_comb begin
		phase_n = phase_q;
		bpos_n = bpos_q;
		bstart_n = bstart_q;
		id_n = id_q;
		hdr_n = hdr_q;
		ext_n = ext_q;
		ones_n = ones_q;
		pulse_n = pulse_q;
		rem_n = rem_q;
		blen_n = blen_q;
		err_n = err_q;
		ppos_n = ppos_q;
		key_n = key_q;
		odd_n = odd_q;
		known_n = known_q;
		seen_n = seen_q;
		done = 1'b0;
		rule = tzxbsd_pkg::start_rule(data_byte);
		ds = tzxbsd_pkg::data_start(id_q);
		if (acc) begin
			case (phase_q)
				tzxbsd_pkg::PH_HEADER: begin
					if ((bpos_q < 32'd8 && data_byte != tzxbsd_pkg::sig_byte(bpos_q[2:0]))
							|| (bpos_q == 32'd8 && data_byte != 8'd1)) begin
						err_n[0] = 1'b1;
						phase_n = tzxbsd_pkg::PH_BAD;
					end else if (bpos_q + 32'd1 >= tzxbsd_pkg::HEADER_BYTES) begin
						phase_n = tzxbsd_pkg::PH_ID;
					end
				end
				tzxbsd_pkg::PH_ID: begin
					id_n = data_byte;
					bstart_n = bpos_q;
					hdr_n = '0;
					ext_n = 32'd0;
					ones_n = 32'd0;
					pulse_n = 32'd0;
					ppos_n = 5'd0;
					odd_n = 1'b0;
					seen_n = 1'b1;
					if (data_byte >= tzxbsd_pkg::ID_JUMP && data_byte <= tzxbsd_pkg::ID_SELECT) begin
						err_n[1] = 1'b1;
					end
					known_n = rule.known;
					key_n = rule.key;
					blen_n = rule.known ? 33'(rule.len) : 33'd0;
					rem_n = blen_n;
					phase_n = tzxbsd_pkg::PH_BODY;
					done = rule.known && rule.len == 4'd0;
				end
				tzxbsd_pkg::PH_BODY: begin
					if (ppos_q < 5'd16) begin
						hdr_n[ppos_q[3:0]] = hdr_q[ppos_q[3:0]] | data_byte;
					end else if (ppos_q < 5'd20) begin
						ext_n[{ppos_q[1:0], 3'b000} +: 8] = ext_q[{ppos_q[1:0], 3'b000} +: 8]
							| data_byte;
					end
					if (ds.has && ppos_q >= ds.pos) begin
						ones_n = ones_q + 32'(popc(data_byte));
					end
					if (id_q == tzxbsd_pkg::ID_PULSES && ppos_q != 5'd0) begin
						pulse_n = pulse_q + (odd_q ? 32'(data_byte) : {16'd0, data_byte, 8'd0});
					end
					if (!known_q) begin
						if (ppos_q == key_q) begin
							blen_n = tzxbsd_pkg::body_len_rule(id_q, hdr_n, ext_n);
							known_n = 1'b1;
							rem_n = blen_n - 33'(ppos_q) - 33'd1;
						end
					end else if (rem_q != 33'd0) begin
						rem_n = rem_q - 33'd1;
					end
					ppos_n = (ppos_q == 5'd31) ? ppos_q : ppos_q + 5'd1;
					odd_n = !odd_q;
					done = known_n && rem_n == 33'd0;
				end
				default: ;
			endcase
			if (done) begin
				phase_n = tzxbsd_pkg::PH_ID;
			end
			bpos_n = bpos_q + 32'd1;
		end
	end

	// Image status after this item
	always_comb begin
		if (phase_n == tzxbsd_pkg::PH_HEADER || phase_n == tzxbsd_pkg::PH_BAD || err_n[0]
				|| !seen_n) begin
			st = tzxbsd_pkg::ST_BAD_SIG;
		end else if (phase_n == tzxbsd_pkg::PH_BODY) begin
			st = tzxbsd_pkg::ST_TRUNC;
		end else if (err_n[1]) begin
			st = tzxbsd_pkg::ST_UNSUP;
		end else begin
			st = tzxbsd_pkg::ST_OK;
		end
	end

	// Hold parser state; return to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tzxbsd_pkg::PH_HEADER;
			bpos_q <= '0; bstart_q <= '0; id_q <= '0; hdr_q <= '0; ext_q <= '0;
			ones_q <= '0; pulse_q <= '0; rem_q <= '0; blen_q <= '0; err_q <= '0;
			ppos_q <= '0; key_q <= '0; odd_q <= 1'b0; known_q <= 1'b0; seen_q <= 1'b0;
		end else if (acc) begin
			if (last_byte) begin
				phase_q <= tzxbsd_pkg::PH_HEADER;
				bpos_q <= '0; bstart_q <= '0; id_q <= '0; hdr_q <= '0; ext_q <= '0;
				ones_q <= '0; pulse_q <= '0; rem_q <= '0; blen_q <= '0; err_q <= '0;
				ppos_q <= '0; key_q <= '0; odd_q <= 1'b0; known_q <= 1'b0; seen_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				bpos_q <= bpos_n; bstart_q <= bstart_n; id_q <= id_n; hdr_q <= hdr_n;
				ext_q <= ext_n; ones_q <= ones_n; pulse_q <= pulse_n; rem_q <= rem_n;
				blen_q <= blen_n; err_q <= err_n; ppos_q <= ppos_n; key_q <= key_n;
				odd_q <= odd_n; known_q <= known_n; seen_q <= seen_n;
			end
		end
	end

	// Register the result item and its play-time operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= acc && (done || last_byte);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			info_s1.blk <= done;
			info_s1.id <= done ? id_n : 8'd0;
			info_s1.offset <= done ? bstart_n - tzxbsd_pkg::HEADER_BYTES : 32'd0;
			info_s1.length <= done ? blen_n + 33'd1 : 33'd0;
			info_s1.done <= last_byte;
			info_s1.status <= last_byte ? st : tzxbsd_pkg::ST_OK;
			ops_s1 <= done ? build_ops(id_n, hdr_n, ones_n, pulse_n, blen_n) : '0;
		end
	end

endmodule

// ===== design/tzxbsd_conv.sv =====
module tzxbsd_conv (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic vld_s1,
	input  tzxbsd_pkg::info_t info_s1,
	input  tzxbsd_pkg::ops_t ops_s1,
	output logic vld_s3,
	output tzxbsd_pkg::info_t info_s3,
	output logic [3:0][20:0] quot_s3,
	output logic [15:0] add_s3
);

	logic vld_s2;
	tzxbsd_pkg::info_t info_s2;
	logic [3:0][31:0] prod_s2;
	logic [15:0] add_s2;
	logic [3:0][47:0] prod_full;
	logic [3:0][60:0] recip;

	// Multiply each term, keeping the low 32 bits
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			prod_full[k] = 48'(ops_s1.a[k]) * 48'(ops_s1.b[k]);
		end
	end

	// Divide by 3500 as a shift by two and a reciprocal multiply by 875
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			recip[k] = 61'(prod_s2[k][31:2]) * 61'(tzxbsd_pkg::DIV875_MUL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			info_s2 <= info_s1;
			add_s2 <= ops_s1.addend;
			for (int k = 0; k < 4; k++) begin
				prod_s2[k] <= prod_full[k][31:0];
				quot_s3[k] <= recip[k][60:40];
			end
			info_s3 <= info_s2;
			add_s3 <= add_s2;
		end
	end

endmodule

// ===== design/tzxbsd_total.sv =====
`include "tzx_block_scanner_duration_defines.svh"

module tzxbsd_total (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic vld_s3,
	input  tzxbsd_pkg::info_t info_s3,
	input  logic [3:0][20:0] quot_s3,
	input  logic [15:0] add_s3,
	input  logic [15:0] max_q,
	output logic vld_s5,
	output tzxbsd_pkg::info_t info_s5,
	output logic [31:0] toff_s5,
	output logic [31:0] dur_s5,
	output logic [15:0] secs_s5
);

	logic vld_s4;
	tzxbsd_pkg::info_t info_s4;
	logic [31:0] dur_s4, toff_s4, tot_s4, total_q;
	logic [31:0] dur, tot_after;
	logic [58:0] recip;
	logic [22:0] secs_raw;
	logic [15:0] secs;

	// Sum the terms and advance the running play time
	always_comb begin
		dur = 32'(quot_s3[0]) + 32'(quot_s3[1]) + 32'(quot_s3[2]) + 32'(quot_s3[3])
			+ 32'(add_s3);
		tot_after = info_s3.blk ? total_q + dur : total_q;
	end

	// Seconds as a shift by three and a reciprocal multiply by 125, then clamp
	always_comb begin
		recip = 59'(tot_s4[31:3]) * 59'(tzxbsd_pkg::DIV125_MUL);
		secs_raw = recip[58:36];
		if (info_s4.status == tzxbsd_pkg::ST_BAD_SIG) begin
			secs = 16'd0;
		end else if (secs_raw > 23'(max_q)) begin
			secs = max_q;
		end else begin
			secs = secs_raw[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			total_q <= '0;
		end else if (advance) begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			if (vld_s3) begin
				total_q <= info_s3.done ? 32'd0 : tot_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			info_s4 <= info_s3;
			dur_s4 <= info_s3.blk ? dur : 32'd0;
			toff_s4 <= info_s3.blk ? total_q : 32'd0;
			tot_s4 <= tot_after;
			info_s5 <= info_s4;
			dur_s5 <= dur_s4;
			toff_s5 <= toff_s4;
			secs_s5 <= info_s4.done ? secs : 16'd0;
		end
	end

	`TZXBSD_AST_NOW(a_noblk_zero, vld_s5 && !info_s5.blk,
		info_s5.length == 33'd0 && dur_s5 == 32'd0 && toff_s5 == 32'd0,
		"block fields set on a result without a block")
	`TZXBSD_AST_NOW(a_secs_limit, vld_s5 && info_s5.done, secs_s5 <= max_q,
		"total seconds above limit")
	`TZXBSD_AST_NOW(a_badsig_secs, vld_s5 && info_s5.done
		&& info_s5.status == tzxbsd_pkg::ST_BAD_SIG, secs_s5 == 16'd0,
		"seconds reported for a bad image")
	`TZXBSD_AST_NEXT(a_total_clear, advance && vld_s3 && info_s3.done, total_q == 32'd0,
		"running time kept past the last byte")

endmodule

// ===== tb/sv/tb_tzx_block_scanner_duration.sv =====
module tb_tzx_block_scanner_duration;
	timeunit 1ns;
	timeprecision 1ps;
	import tzxbsd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int NO_KEY = 255;
	localparam logic [7:0] SIG [8] = '{8'h5A, 8'h58, 8'h54, 8'h61, 8'h70, 8'h65, 8'h21, 8'h1A};
	localparam logic [7:0] ALL_IDS [23] = '{ID_STD, ID_TURBO, ID_TONE, ID_PULSES, ID_PURE,
		ID_DIRECT, ID_PAUSE, ID_GRP_START, ID_GRP_END, ID_JUMP, ID_LOOP_START, ID_LOOP_END,
		ID_CALL_SEQ, ID_RET_SEQ, ID_SELECT, ID_TEXT, ID_MESSAGE, ID_ARCHIVE, ID_HARDWARE,
		ID_EMU_INFO, ID_CUSTOM, ID_SNAPSHOT, ID_GLUE};

	typedef struct {
		logic blk;
		logic [7:0] id;
		logic [31:0] offset;
		logic [32:0] length;
		logic [31:0] toff;
		logic [31:0] dur;
		logic idone;
		logic [1:0] st;
		logic [15:0] secs;
	} scan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = 16'h0000;
	logic out_valid;
	logic out_ready = 1'b0;
	logic block_valid;
	logic [7:0] tape_id;
	logic [31:0] block_offset;
	logic [32:0] block_length;
	logic [31:0] start_ms;
	logic [31:0] play_time_ms;
	logic image_done;
	logic [1:0] status;
	logic [15:0] total_seconds;

	tzx_block_scanner_duration dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .last_byte(last_byte),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.block_valid(block_valid), .tape_id(tape_id), .block_offset(block_offset),
		.block_length(block_length), .start_ms(start_ms),
		.play_time_ms(play_time_ms), .image_done(image_done), .status(status),
		.total_seconds(total_seconds)
	);

	always #4 clk = ~clk;

	// Scanner state mirror
	phase_t ph;
	logic [31:0] pos, bstart, ones, psum, tot_ms, ext;
	logic [7:0] cid;
	logic [7:0] hb [16];
	logic [63:0] rem, bpos, blen;
	logic [1:0] eflags;
	int key;
	bit known, seen;
	logic [15:0] max_secs = 16'hFFFF;

	scan_result_t pending_results[$];
	logic [7:0] img_q[$];
	int send_idle = 0, stall_pct = 0, hold_cnt = 0;
	int err_cnt = 0, n_items = 0, n_images = 0, n_blocks = 0, n_results = 0;
	int st_seen [4] = '{0, 0, 0, 0};
	int cycles = 0;

	function automatic logic [31:0] conv(input logic [31:0] ts, input logic [31:0] n);
		logic [31:0] m;
		m = ts * n;
		return m / 32'd3500;
	endfunction

	function automatic logic [31:0] fb(input int p);
		return (p < 16) ? {24'h0, hb[p]} : 32'h0;
	endfunction

	function automatic logic [31:0] fw(input int p);
		return fb(p) | (fb(p + 1) << 8);
	endfunction

	function automatic logic [31:0] ft(input int p);
		return fw(p) | (fb(p + 2) << 16);
	endfunction

	task automatic clear_scan();
		ph = PH_HEADER;
		pos = 0; bstart = 0; cid = 0; ones = 0; psum = 0; tot_ms = 0; ext = 0;
		foreach (hb[i]) hb[i] = 8'h00;
		rem = 0; bpos = 0; blen = 0; eflags = 0;
		key = NO_KEY; known = 0; seen = 0;
	endtask

	function automatic logic [63:0] length_rule(input logic [7:0] id);
		case (id)
			ID_STD: return 64'(fw(2)) + 4;
			ID_TURBO: return 64'(fb(15) | ((ext & 32'hFFFF) << 8)) + 18;
			ID_PULSES: return 64'(fb(0)) * 2 + 1;
			ID_PURE: return 64'(ft(7)) + 10;
			ID_DIRECT: return 64'(ft(5)) + 8;
			ID_GRP_START, ID_TEXT: return 64'(fb(0)) + 1;
			ID_CALL_SEQ: return 64'(fw(0)) * 2 + 2;
			ID_SELECT, ID_ARCHIVE: return 64'(fw(0)) + 2;
			ID_MESSAGE: return 64'(fb(1)) + 2;
			ID_HARDWARE: return 64'(fb(0)) * 3 + 1;
			ID_CUSTOM: return 64'(ext) + 20;
			ID_SNAPSHOT: return 64'(ft(1)) + 4;
			default: return 64'(fw(0) | (fw(2) << 16)) + 4;
		endcase
	endfunction

	function automatic logic [31:0] play_ms(input logic [7:0] id);
		logic [31:0] dl, ns, d;
		case (id)
			ID_STD: begin
				ns = fw(2) * 8;
				d = conv(2168, 3220) + conv(667 + 735, 1);
				d += conv(1710, ones * 2) + conv(855, (ns - ones) * 2);
				return d + fw(0);
			end
			ID_TURBO: begin
				dl = 32'(blen - 18);
				ns = (dl - 1) * 8 + fb(12);
				d = conv(fw(0), fw(10)) + conv(fw(2) + fw(4), 1);
				d += conv(fw(8), ones * 2) + conv(fw(6), (ns - ones) * 2);
				return d + fw(13);
			end
			ID_TONE: return conv(fw(0), fw(2));
			ID_PULSES: return psum / 32'd3500;
			ID_PURE: begin
				dl = 32'(blen - 10);
				ns = (dl - 1) * 8 + fb(4);
				d = conv(fw(2), ones * 2) + conv(fw(0), (ns - ones) * 2);
				return d + fw(5);
			end
			ID_DIRECT: begin
				dl = 32'(blen - 8);
				ns = (dl - 1) * 8 + fb(4);
				return conv(fw(0), ns) + fw(2);
			end
			ID_PAUSE: return fw(0);
			default: return 32'h0;
		endcase
	endfunction

	function automatic bit open_block(input logic [7:0] b);
		cid = b;
		bstart = pos;
		foreach (hb[i]) hb[i] = 8'h00;
		ext = 0; ones = 0; psum = 0; bpos = 0;
		known = 1; key = NO_KEY; seen = 1;
		if (b >= ID_JUMP && b <= ID_SELECT) eflags |= 2'b10;
		case (b)
			ID_TONE: blen = 4;
			ID_PAUSE, ID_JUMP, ID_LOOP_START: blen = 2;
			ID_GRP_END, ID_LOOP_END, ID_RET_SEQ: blen = 0;
			ID_EMU_INFO: blen = 8;
			ID_GLUE: blen = 9;
			ID_TURBO: key = 17;
			ID_PULSES, ID_GRP_START, ID_TEXT, ID_HARDWARE: key = 0;
			ID_PURE: key = 9;
			ID_DIRECT: key = 7;
			ID_CALL_SEQ, ID_SELECT, ID_MESSAGE, ID_ARCHIVE: key = 1;
			ID_CUSTOM: key = 19;
			default: key = 3;
		endcase
		if (key != NO_KEY) begin
			known = 0;
			blen = 0;
		end
		rem = blen;
		ph = PH_BODY;
		return known && blen == 0;
	endfunction

	function automatic bit take_body(input logic [7:0] b);
		logic [63:0] p;
		int ds;
		p = bpos;
		ds = (cid == ID_STD) ? 4 : (cid == ID_TURBO) ? 18 : (cid == ID_PURE) ? 10 : NO_KEY;
		if (p < 16) hb[p] = b;
		else if (p < 20) ext |= 32'(b) << ((p - 16) * 8);
		if (ds != NO_KEY && p >= ds) ones += $countones(b);
		if (cid == ID_PULSES && p >= 1) psum += p[0] ? 32'(b) : (32'(b) << 8);
		if (!known) begin
			if (p == key) begin
				blen = length_rule(cid);
				known = 1;
				rem = blen - (p + 1);
			end
		end else if (rem > 0) begin
			rem--;
		end
		bpos = p + 1;
		return known && rem == 0;
	endfunction

	// Advance the mirror by one accepted item and queue its result, if any
	task automatic scan_byte(input logic [7:0] b, input logic last);
		scan_result_t r;
		bit done;
		logic [31:0] d;
		r = '{default: '0};
		done = 0;
		case (ph)
			PH_HEADER: begin
				if ((pos < 8 && b != SIG[pos]) || (pos == 8 && b != 8'h01)) begin
					eflags |= 2'b01;
					ph = PH_BAD;
				end else if (pos + 1 >= HEADER_BYTES) begin
					ph = PH_ID;
				end
			end
			PH_ID: done = open_block(b);
			PH_BODY: done = take_body(b);
			default: ;
		endcase
		if (done) begin
			d = play_ms(cid);
			r.blk = 1;
			r.id = cid;
			r.offset = bstart - HEADER_BYTES;
			r.length = 33'(blen + 1);
			r.toff = tot_ms;
			r.dur = d;
			tot_ms += d;
			ph = PH_ID;
		end
		pos++;
		if (last) begin
			if (ph == PH_HEADER || ph == PH_BAD || eflags[0] || !seen) r.st = ST_BAD_SIG;
			else if (ph == PH_BODY) r.st = ST_TRUNC;
			else if (eflags[1]) r.st = ST_UNSUP;
			else r.st = ST_OK;
			d = (r.st == ST_BAD_SIG) ? 0 : tot_ms / 1000;
			if (d > max_secs) d = max_secs;
			r.idone = 1;
			r.secs = d[15:0];
			clear_scan();
		end
		if (done || last) pending_results.push_back(r);
	endtask

	// Drive receiver stalls; a hold-off request overrides the random ones
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			out_ready <= 1'b0;
			hold_cnt--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		scan_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected");
				err_cnt++;
			end else begin
				e = pending_results.pop_front();
				n_results++;
				if (e.blk) n_blocks++;
				if (e.idone) st_seen[e.st]++;
				if (block_valid !== e.blk) begin
					$error("block_valid exp %0h got %0h", e.blk, block_valid); err_cnt++;
				end
				if (tape_id !== e.id) begin
					$error("tape_id exp %0h got %0h", e.id, tape_id); err_cnt++;
				end
				if (block_offset !== e.offset) begin
					$error("block_offset exp %0h got %0h", e.offset, block_offset); err_cnt++;
				end
				if (block_length !== e.length) begin
					$error("block_length exp %0h got %0h", e.length, block_length); err_cnt++;
				end
				if (start_ms !== e.toff) begin
					$error("start_ms exp %0h got %0h", e.toff, start_ms);
					err_cnt++;
				end
				if (play_time_ms !== e.dur) begin
					$error("play_time_ms exp %0h got %0h", e.dur, play_time_ms); err_cnt++;
				end
				if (image_done !== e.idone) begin
					$error("image_done exp %0h got %0h", e.idone, image_done); err_cnt++;
				end
				if (status !== e.st) begin
					$error("status exp %0h got %0h", e.st, status); err_cnt++;
				end
				if (total_seconds !== e.secs) begin
					$error("total_seconds exp %0h got %0h", e.secs, total_seconds);
					err_cnt++;
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Offer one item, hold it until accepted, then idle at random
	task automatic send_item(input logic [7:0] b, input logic last);
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		scan_byte(b, last);
		n_items++;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_image();
		foreach (img_q[i]) send_item(img_q[i], i == img_q.size() - 1);
		img_q.delete();
		n_images++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		max_secs = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_rand(input int k);
		repeat (k) img_q.push_back(8'($urandom));
	endtask

	task automatic push_header();
		foreach (SIG[i]) img_q.push_back(SIG[i]);
		img_q.push_back(8'h01);
		push_rand(1);
	endtask

	// Append one well-formed block with a short body
	task automatic push_block(input logic [7:0] id);
		logic [7:0] n;
		n = 8'($urandom_range(0, 6));
		img_q.push_back(id);
		case (id)
			ID_STD: begin push_rand(2); img_q.push_back(n); img_q.push_back(0); push_rand(n); end
			ID_TURBO: begin
				push_rand(15); img_q.push_back(n); img_q.push_back(0); img_q.push_back(0);
				push_rand(n);
			end
			ID_TONE: push_rand(4);
			ID_PULSES: begin img_q.push_back(n); push_rand(2 * n); end
			ID_PURE: begin
				push_rand(7); img_q.push_back(n); img_q.push_back(0); img_q.push_back(0);
				push_rand(n);
			end
			ID_DIRECT: begin
				push_rand(5); img_q.push_back(n); img_q.push_back(0); img_q.push_back(0);
				push_rand(n);
			end
			ID_PAUSE, ID_JUMP, ID_LOOP_START: push_rand(2);
			ID_GRP_END, ID_LOOP_END, ID_RET_SEQ: ;
			ID_GRP_START, ID_TEXT: begin img_q.push_back(n); push_rand(n); end
			ID_CALL_SEQ: begin img_q.push_back(n); img_q.push_back(0); push_rand(2 * n); end
			ID_SELECT, ID_ARCHIVE: begin img_q.push_back(n); img_q.push_back(0); push_rand(n); end
			ID_MESSAGE: begin push_rand(1); img_q.push_back(n); push_rand(n); end
			ID_HARDWARE: begin img_q.push_back(n); push_rand(3 * n); end
			ID_EMU_INFO: push_rand(8);
			ID_GLUE: push_rand(9);
			ID_CUSTOM: begin
				push_rand(16); img_q.push_back(n); repeat (3) img_q.push_back(0); push_rand(n);
			end
			ID_SNAPSHOT: begin
				push_rand(1); img_q.push_back(n); img_q.push_back(0); img_q.push_back(0);
				push_rand(n);
			end
			default: begin img_q.push_back(n); repeat (3) img_q.push_back(0); push_rand(n); end
		endcase
	endtask

	function automatic logic [7:0] pick_id();
		if ($urandom_range(99) < 5) return 8'($urandom);
		return ALL_IDS[$urandom_range(0, 22)];
	endfunction

	// Build and send one image of a randomly chosen shape
	task automatic random_image();
		int kind, k;
		kind = $urandom_range(99);
		push_header();
		if (kind < 70) begin
			repeat ($urandom_range(1, 6)) push_block(pick_id());
		end else if (kind < 80) begin
			// cut the last block short so the image ends inside it
			repeat ($urandom_range(0, 3)) push_block(pick_id());
			k = img_q.size();
			push_block(pick_id());
			if (img_q.size() - k > 1) repeat ($urandom_range(1, img_q.size() - k - 1))
				void'(img_q.pop_back());
		end else if (kind < 85) begin
			k = $urandom_range(0, 8);
			img_q[k] = img_q[k] ^ 8'($urandom_range(1, 255));
			push_rand($urandom_range(0, 10));
		end else if (kind < 95) begin
			push_rand($urandom_range(1, 20));
		end else begin
			// huge length field: the image always ends inside this block
			push_block(pick_id());
			img_q.push_back(8'hFF);
			push_rand(3);
			img_q.push_back(8'($urandom_range(1, 255)));
			push_rand($urandom_range(0, 6));
		end
		send_image();
	endtask

	task automatic test_directed();
		// short image, bad version, then header with two tiny blocks
		img_q = '{SIG[0], SIG[1]};
		send_image();
		foreach (SIG[i]) img_q.push_back(SIG[i]);
		img_q.push_back(8'h02);
		send_image();
		push_header();
		img_q.push_back(ID_GRP_END);
		img_q.push_back(ID_PAUSE);
		img_q.push_back(8'hFF);
		img_q.push_back(8'hFF);
		send_image();
		// header with nothing after it
		push_header();
		send_image();
	endtask

	task automatic test_all_ids();
		push_header();
		foreach (ALL_IDS[i]) push_block(ALL_IDS[i]);
		send_image();
	endtask

	task automatic test_random(input int target, input int idle, input int stall);
		int stop;
		send_idle = idle;
		stall_pct = stall;
		stop = n_items + target;
		while (n_items < stop) random_image();
		send_idle = 0;
		stall_pct = 0;
	endtask

	task automatic test_backpressure();
		int stop;
		hold_cnt = 400;
		stop = n_items + 80;
		while (n_items < stop) random_image();
	endtask

	task automatic test_drain_pause();
		random_image();
		wait_idle();
		random_image();
	endtask

	initial begin
		clear_scan();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_limit(16'hFFFF);
		test_directed();
		test_all_ids();
		write_limit(16'h0000);
		test_random(150, 0, 0);
		write_limit(16'h0001);
		test_random(150, 55, 0);
		write_limit(16'($urandom));
		test_random(150, 0, 55);
		write_limit(16'($urandom_range(0, 200)));
		test_random(150, 15, 15);
		write_limit(16'hFFFF);
		test_backpressure();
		test_drain_pause();
		wait_idle();
		$display("%0d items in %0d images, %0d results, %0d blocks", n_items, n_images,
			n_results, n_blocks);
		$display("image status ok/bad/trunc/unsup: %0d/%0d/%0d/%0d", st_seen[0], st_seen[1],
			st_seen[2], st_seen[3]);
		if (err_cnt == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
